[design/gfd_pkg.sv]
// Package for the gamepad frame decoder: frame positions, the result status
// codes and the sizes of the stored frame bytes. No dependencies.
`default_nettype none

package gfd_pkg;

  localparam int unsigned PosWidth    = 4;
  localparam int unsigned PayloadLen  = 5;  // bytes 3 to 7 are held; byte 8 arrives live
  localparam int unsigned PayloadIdxW = $clog2(PayloadLen);

  localparam logic [PosWidth-1:0] PosFirstPayload = 4'd3;
  localparam logic [PosWidth-1:0] PosLastPayload  = 4'd7;
  localparam logic [PosWidth-1:0] PosFrameLast    = 4'd8;
  localparam logic [PosWidth-1:0] PosIdle         = 4'd9;

  localparam logic [7:0]  ByteAllOnes   = 8'hFF;
  localparam logic [7:0]  ByteAllZeros  = 8'h00;
  localparam logic [7:0]  StickCentre   = 8'd127;
  localparam logic [15:0] ButtonsNone   = 16'hFFFF;

  typedef enum logic [1:0] {
    STATUS_SAME    = 2'd0,
    STATUS_CHANGED = 2'd1,
    STATUS_DEAD    = 2'd2
  } status_e;

endpackage

`default_nettype wire

[design/gamepad_frame_decoder.sv]
// Results are registered: one shows in the cycle after byte 8 is accepted.
// Throughput: one byte per cycle; a byte offered at byte 8, even one with a start
// mark, waits while the previous result is still held by a stalled output.
// Reset (rst_ni low, asynchronous) clears the byte position, the held buttons and
// sticks, and the output valid; the first byte after reset counts as byte 0.
// Top level of the gamepad poll-reply decoder; depends on gfd_pkg only.
`default_nettype none

module gamepad_frame_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        frame_start_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [15:0]      buttons_o,
  output logic [7:0]       right_x_o,
  output logic [7:0]       right_y_o,
  output logic [7:0]       left_x_o,
  output logic [7:0]       left_y_o
);

  // Frame tracking state. The position names the byte that the next request
  // carries; it parks at the idle value after byte 8 until a start mark.
  logic [gfd_pkg::PosWidth-1:0] pos_q, pos_d;
  logic                         ones_q, ones_d;
  logic                         zeros_q, zeros_d;

  // Bytes 3 to 7 of the frame in progress. They are always written before
  // the frame's last byte reads them, so they carry no reset.
  logic [7:0] payload_q [gfd_pkg::PayloadLen];

  // Decoded state, which also drives the result payload directly.
  logic [15:0]          held_buttons_q;
  logic [7:0]           held_sticks_q [4];
  gfd_pkg::status_e     status_q, status_d;
  logic                 out_valid_q, out_valid_d;

  logic                         accept;
  logic                         active;
  logic                         result_fire;
  logic                         dead;
  logic [gfd_pkg::PosWidth-1:0] pos_eff;
  logic [gfd_pkg::PosWidth-1:0] idx_full;
  logic [gfd_pkg::PayloadIdxW-1:0] idx;
  logic                         ones_eff, zeros_eff;
  logic                         payload_wr;
  logic [15:0]                  new_buttons;
  logic [7:0]                   new_sticks [4];
  logic                         sticks_unplugged;
  logic                         changed;

  // A byte offered at byte 8, even one with a start mark, must wait while the
  // previous result is still stalled at the output; all other bytes flow on.
  assign in_stall_o = out_valid_q && out_stall_i && (pos_q == gfd_pkg::PosFrameLast);
  assign accept     = in_valid_i && !in_stall_o;

  // A start mark restarts the frame before the byte is looked at.
  assign pos_eff   = frame_start_i ? '0 : pos_q;
  assign ones_eff  = frame_start_i | ones_q;
  assign zeros_eff = frame_start_i | zeros_q;
  assign active    = pos_eff <= gfd_pkg::PosFrameLast;

  assign ones_d  = ones_eff  && (rx_byte_i == gfd_pkg::ByteAllOnes);
  assign zeros_d = zeros_eff && (rx_byte_i == gfd_pkg::ByteAllZeros);
  assign pos_d   = (pos_eff == gfd_pkg::PosFrameLast) ? gfd_pkg::PosIdle
                                                      : pos_eff + 4'd1;

  assign idx_full   = pos_eff - gfd_pkg::PosFirstPayload;
  assign idx        = idx_full[gfd_pkg::PayloadIdxW-1:0];
  assign payload_wr = accept && (pos_eff >= gfd_pkg::PosFirstPayload)
                      && (pos_eff <= gfd_pkg::PosLastPayload);

  assign result_fire = accept && (pos_eff == gfd_pkg::PosFrameLast);
  // A frame is dead when every one of its nine bytes was 0xFF, or every one 0x00.
  assign dead        = ones_d || zeros_d;

  // Buttons are sent active low: invert bytes 3 and 4, byte 4 in the high half.
  // 0xFFFF after inversion (every bit low on the wire) is treated as nothing pressed.
  always_comb begin
    new_buttons = ~{payload_q[1], payload_q[0]};
    if (new_buttons == gfd_pkg::ButtonsNone) begin
      new_buttons = '0;
    end
  end

  // Sticks are bytes 5 to 8; byte 8 comes straight from the request. All four
  // reading 255 means the pad is in digital mode, so the sticks are centred.
  assign sticks_unplugged = (payload_q[2] == gfd_pkg::ByteAllOnes)
                            && (payload_q[3] == gfd_pkg::ByteAllOnes)
                            && (payload_q[4] == gfd_pkg::ByteAllOnes)
                            && (rx_byte_i == gfd_pkg::ByteAllOnes);

  always_comb begin
    if (sticks_unplugged) begin
      new_sticks[0] = gfd_pkg::StickCentre;
      new_sticks[1] = gfd_pkg::StickCentre;
      new_sticks[2] = gfd_pkg::StickCentre;
      new_sticks[3] = gfd_pkg::StickCentre;
    end else begin
      new_sticks[0] = payload_q[2];
      new_sticks[1] = payload_q[3];
      new_sticks[2] = payload_q[4];
      new_sticks[3] = rx_byte_i;
    end
  end

  assign changed = (new_buttons != held_buttons_q)
                   || (new_sticks[0] != held_sticks_q[0])
                   || (new_sticks[1] != held_sticks_q[1])
                   || (new_sticks[2] != held_sticks_q[2])
                   || (new_sticks[3] != held_sticks_q[3]);

  always_comb begin
    if (dead) begin
      status_d = gfd_pkg::STATUS_DEAD;
    end else if (changed) begin
      status_d = gfd_pkg::STATUS_CHANGED;
    end else begin
      status_d = gfd_pkg::STATUS_SAME;
    end
  end

  // The output holds its result until it is taken; a new result may replace
  // it in the very cycle it is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (result_fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q          <= '0;
      ones_q         <= 1'b1;
      zeros_q        <= 1'b1;
      out_valid_q    <= 1'b0;
      status_q       <= gfd_pkg::STATUS_SAME;
      held_buttons_q <= '0;
      held_sticks_q  <= '{default: '0};
    end else begin
      out_valid_q <= out_valid_d;
      if (accept && active) begin
        pos_q   <= pos_d;
        ones_q  <= ones_d;
        zeros_q <= zeros_d;
      end else if (accept) begin
        // Bytes past the end of a frame are dropped and the position stays idle;
        // a byte with a start mark is active and is taken by the branch above.
        pos_q <= pos_eff;
      end
      if (result_fire) begin
        status_q <= status_d;
        if (!dead) begin
          held_buttons_q <= new_buttons;
          held_sticks_q  <= new_sticks;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (payload_wr) begin
      payload_q[idx] <= rx_byte_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign buttons_o   = held_buttons_q;
  assign right_x_o   = held_sticks_q[0];
  assign right_y_o   = held_sticks_q[1];
  assign left_x_o    = held_sticks_q[2];
  assign left_y_o    = held_sticks_q[3];

  // The byte position never goes beyond the idle value.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= gfd_pkg::PosIdle)
    else $error("byte position out of range");

  // Input is only held back on behalf of a waiting result.
  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with no result pending");

  // A dead frame leaves the decoded state untouched.
  a_dead_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_fire && dead) |=> ($stable(held_buttons_q) && $stable(held_sticks_q[0])
      && $stable(held_sticks_q[1]) && $stable(held_sticks_q[2])
      && $stable(held_sticks_q[3]) && status_q == gfd_pkg::STATUS_DEAD))
    else $error("dead frame altered the held state");

  // An unchanged report keeps the held buttons and the left Y stick stable.
  a_same_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_fire && !dead && !changed) |=> (status_q == gfd_pkg::STATUS_SAME
      && $stable(held_buttons_q) && $stable(held_sticks_q[3])))
    else $error("unchanged status with altered state");

  // A completed frame always leaves a result at the output.
  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_fire |=> out_valid_q)
    else $error("completed frame gave no result");

endmodule

`default_nettype wire

[verif/tb_gamepad_frame_decoder.sv]
// Self-checking testbench for gamepad_frame_decoder: it feeds poll-reply bytes,
// predicts every decoded result in step with the requests and checks each one.
// Depends on gfd_pkg and the gamepad_frame_decoder top level only.

module tb_gamepad_frame_decoder;

  // Nine bytes of one poll reply; element 0 is byte 0 of the frame.
  typedef logic [8:0][7:0] pad_frame_t;

  // One decoded result as the block should present it.
  typedef struct packed {
    gfd_pkg::status_e status;
    logic [15:0]      buttons;
    logic [7:0]       right_x;
    logic [7:0]       right_y;
    logic [7:0]       left_x;
    logic [7:0]       left_y;
  } pad_report_t;

  localparam int CycleLimit = 400000;

  // Clock, reset and every input of the block start at known values.
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic [7:0]  rx_byte_i     = 8'h00;
  logic        frame_start_i = 1'b0;
  logic        out_stall_i   = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic [15:0] buttons_o;
  logic [7:0]  right_x_o;
  logic [7:0]  right_y_o;
  logic [7:0]  left_x_o;
  logic [7:0]  left_y_o;

  // Traffic shaping, set by each test phase.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_cycles   = 0;

  // Bookkeeping.
  int cycle_count    = 0;
  int error_count    = 0;
  int bytes_sent     = 0;
  int reports_seen   = 0;
  int dead_seen      = 0;

  // Predicted decoder state, kept in step with the requests the block accepts.
  logic [3:0]      pad_pos       = '0;
  logic            pad_all_ones  = 1'b1;
  logic            pad_all_zeros = 1'b1;
  logic [5:0][7:0] pad_payload   = '0;
  logic [15:0]     pad_buttons   = '0;
  logic [3:0][7:0] pad_sticks    = '0;

  pad_report_t pad_expected[$];
  pad_frame_t  last_frame = '0;

  gamepad_frame_decoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .frame_start_i(frame_start_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .buttons_o    (buttons_o),
    .right_x_o    (right_x_o),
    .right_y_o    (right_y_o),
    .left_x_o     (left_x_o),
    .left_y_o     (left_y_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watchdog: a correct run finishes far inside this limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Watchdog expired after %0d cycles with %0d results outstanding.",
               cycle_count, pad_expected.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    error_count++;
    $display("[%0d] ERROR: %s", cycle_count, msg);
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) begin
      flag_error($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // Advances the predicted decoder by one accepted byte. A start mark rewinds
  // the frame; bytes beyond byte 8 without a new mark are ignored. Byte 8
  // either rejects the frame as dead or decodes and stores it.
  task automatic predict_byte(input logic [7:0] rx, input logic start,
                              output bit has_report, output pad_report_t rep);
    logic [15:0]     new_buttons;
    logic [3:0][7:0] new_sticks;
    has_report = 1'b0;
    rep = '0;
    if (start) begin
      pad_pos = '0;
      pad_all_ones = 1'b1;
      pad_all_zeros = 1'b1;
    end
    if (pad_pos <= gfd_pkg::PosFrameLast) begin
      if (rx != gfd_pkg::ByteAllOnes) pad_all_ones = 1'b0;
      if (rx != gfd_pkg::ByteAllZeros) pad_all_zeros = 1'b0;
      if (pad_pos >= gfd_pkg::PosFirstPayload) begin
        pad_payload[pad_pos - gfd_pkg::PosFirstPayload] = rx;
      end
      if (pad_pos < gfd_pkg::PosFrameLast) begin
        pad_pos = pad_pos + 4'd1;
      end else begin
        pad_pos = gfd_pkg::PosIdle;
        has_report = 1'b1;
        if (pad_all_ones || pad_all_zeros) begin
          rep.status = gfd_pkg::STATUS_DEAD;
        end else begin
          // Buttons are active low on the wire; nothing pressed reads as zero.
          new_buttons = ~{pad_payload[1], pad_payload[0]};
          if (new_buttons == gfd_pkg::ButtonsNone) new_buttons = '0;
          new_sticks = pad_payload[5:2];
          if (new_sticks == {4{gfd_pkg::ByteAllOnes}}) begin
            new_sticks = {4{gfd_pkg::StickCentre}};
          end
          rep.status = (new_buttons != pad_buttons || new_sticks != pad_sticks) ?
                       gfd_pkg::STATUS_CHANGED : gfd_pkg::STATUS_SAME;
          pad_buttons = new_buttons;
          pad_sticks = new_sticks;
        end
        rep.buttons = pad_buttons;
        rep.right_x = pad_sticks[0];
        rep.right_y = pad_sticks[1];
        rep.left_x  = pad_sticks[2];
        rep.left_y  = pad_sticks[3];
      end
    end
  endtask

  // Offers one byte, after a random idle gap, and holds it until the block
  // takes the request. The prediction is made at the edge of acceptance.
  task automatic send_byte(input logic [7:0] rx, input logic start);
    bit          has_report;
    pad_report_t rep;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    rx_byte_i     <= rx;
    frame_start_i <= start;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_byte(rx, start, has_report, rep);
    bytes_sent++;
    if (has_report) pad_expected.push_back(rep);
  endtask

  task automatic send_frame(input pad_frame_t f, input int len, input bit marked);
    for (int i = 0; i < len; i++) begin
      send_byte(f[i], marked && i == 0);
    end
  endtask

  // The sender falls silent until every predicted result has been taken.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pad_expected.size() != 0) @(posedge clk_i);
  endtask

  // Mostly well-formed replies with random content, weighted towards the
  // corner cases: dead frames, repeats, no buttons, parked sticks.
  task automatic make_frame(output pad_frame_t f);
    int kind;
    kind = $urandom_range(99);
    for (int i = 0; i < 9; i++) f[i] = 8'($urandom_range(255));
    if (kind < 8) begin
      f = {9{gfd_pkg::ByteAllOnes}};
    end else if (kind < 16) begin
      f = {9{gfd_pkg::ByteAllZeros}};
    end else if (kind < 26) begin
      f = last_frame;
    end else if (kind < 34) begin
      f[4:3] = {2{gfd_pkg::ByteAllZeros}};
    end else if (kind < 42) begin
      f[8:5] = {4{gfd_pkg::ByteAllOnes}};
    end else if (kind < 48) begin
      f[4:3] = {2{gfd_pkg::ByteAllOnes}};
    end else if (kind < 54) begin
      // Nearly dead: one byte may differ from the idle-line pattern.
      f = {9{gfd_pkg::ByteAllOnes}};
      f[$urandom_range(8)] = 8'($urandom_range(255));
    end
    last_frame = f;
  endtask

  // Random traffic for one idle/stall mix. Short frames and stray bytes after
  // byte 8 are mixed in; the strays are ignored by the block and not counted.
  task automatic run_traffic(input int n_bytes, input int idle_p, input int stall_p);
    pad_frame_t f;
    int         counted;
    int         len;
    send_idle_pct = idle_p;
    stall_pct     = stall_p;
    counted       = 0;
    while (counted < n_bytes) begin
      make_frame(f);
      if ($urandom_range(99) < 8) begin
        len = $urandom_range(1, 8);
        send_frame(f, len, 1'b1);
        counted += len;
      end else begin
        send_frame(f, 9, 1'b1);
        counted += 9;
        if ($urandom_range(99) < 6) begin
          for (int i = 0; i < $urandom_range(1, 3); i++) begin
            send_byte(8'($urandom_range(255)), 1'b0);
          end
        end
      end
    end
    drain_results();
  endtask

  // First frame after reset carries no start mark; it still counts as byte 0.
  // Both button bytes read zero (everything pressed on the wire, forced to none)
  // and all sticks read 255, which parks them at centre. A stray byte follows.
  task automatic test_unmarked_first_frame();
    pad_frame_t f;
    f = {{4{gfd_pkg::ByteAllOnes}}, {2{gfd_pkg::ByteAllZeros}}, 8'h5A,
         gfd_pkg::ByteAllOnes, gfd_pkg::ByteAllZeros};
    last_frame = f;
    send_frame(f, 9, 1'b0);
    send_byte(8'hA5, 1'b0);
    drain_results();
  endtask

  // An idle-line frame of all ones is rejected and the stored state survives.
  task automatic test_dead_frame();
    send_frame({9{gfd_pkg::ByteAllOnes}}, 9, 1'b1);
    drain_results();
  endtask

  // A start mark two bytes into a frame abandons it; the repeated first frame
  // then decodes to the same state and must report no change.
  task automatic test_restart_mid_frame();
    send_byte(gfd_pkg::ByteAllOnes, 1'b1);
    send_byte(gfd_pkg::ByteAllZeros, 1'b0);
    send_frame(last_frame, 9, 1'b1);
    drain_results();
  endtask

  // The receiver holds off for a long stretch while frames keep coming, so a
  // finished result blocks the output and the block stalls its input.
  task automatic test_output_hold();
    pad_frame_t f;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_cycles  <= 60;
    for (int n = 0; n < 4; n++) begin
      make_frame(f);
      send_frame(f, 9, 1'b1);
    end
    in_valid_i <= 1'b0;
    while (hold_cycles != 0) @(posedge clk_i);
    drain_results();
  endtask

  // Output side: random stalls, or a counted hold when a test asks for one.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Every result taken by the receiver is matched against the oldest prediction.
  always @(posedge clk_i) begin
    pad_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pad_expected.size() == 0) begin
        flag_error($sformatf("unexpected result, status %0d", status_o));
      end else begin
        want = pad_expected.pop_front();
        reports_seen++;
        if (want.status == gfd_pkg::STATUS_DEAD) dead_seen++;
        compare_field("status", status_o, want.status);
        compare_field("buttons", buttons_o, want.buttons);
        compare_field("right_x", right_x_o, want.right_x);
        compare_field("right_y", right_y_o, want.right_y);
        compare_field("left_x", left_x_o, want.left_x);
        compare_field("left_y", left_y_o, want.left_y);
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unmarked_first_frame();
    test_dead_frame();
    test_restart_mid_frame();

    run_traffic(160, 0, 0);
    run_traffic(150, 69, 0);
    run_traffic(150, 0, 69);
    run_traffic(150, 6, 6);
    test_output_hold();

    repeat (8) @(posedge clk_i);
    if (pad_expected.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pad_expected.size()));
    end

    $display("Sent %0d bytes; checked %0d results, %0d of them dead frames,",
             bytes_sent, reports_seen, dead_seen);
    $display("under free flow, sender gaps, receiver stalls and a long output hold.");
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches found.", error_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
design/gfd_pkg.sv
design/gamepad_frame_decoder.sv
verif/tb_gamepad_frame_decoder.sv
